@@ rtl/vang_pkg.sv @@
// shared types, widths and constants of the 3-d vector angle block
package vang_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH     = 4;

    localparam int TOP_BIT  = 23;
    localparam int MAG_W    = TOP_BIT + 1;
    localparam int PROD_W   = 2 * MAG_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int DOT_W    = SUM_W + 1;
    localparam int NORM_SH  = 12;
    localparam int RAD_W    = SUM_W + NORM_SH;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int DEN_SH   = 30;
    localparam int DEN_W    = 2 * ROOT_W - DEN_SH;
    localparam int Q_W      = 31;
    localparam int CX_W     = 34;
    localparam int Z_W      = 32;
    localparam int ANG_W    = 24;
    localparam int CORDIC_STEPS = 25;

    localparam logic [Q_W-1:0]   ONE_Q30   = Q_W'(1) << 30;
    localparam logic [RAD_W-1:0] ONE_Q60   = RAD_W'(1) << 60;
    localparam logic [ANG_W-1:0] ANGLE_MAX = ANG_W'(180) << 16;
    localparam logic signed [Z_W-1:0] Z_PREROT = Z_W'(90) << 20;

    typedef struct packed {
        logic                  zero;
        logic [2:0]            a_neg;
        logic [2:0]            b_neg;
        logic [2:0][MAG_W-1:0] a_mag;
        logic [2:0][MAG_W-1:0] b_mag;
    } t_pair;

    // atan(2^-i) in degrees, q.20
    function automatic logic signed [Z_W-1:0] atan_q20(input int unsigned idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = 32'sd47185920;
            1:       v = 32'sd27855475;
            2:       v = 32'sd14718068;
            3:       v = 32'sd7471121;
            4:       v = 32'sd3750058;
            5:       v = 32'sd1876857;
            6:       v = 32'sd938658;
            7:       v = 32'sd469357;
            8:       v = 32'sd234682;
            9:       v = 32'sd117342;
            10:      v = 32'sd58671;
            11:      v = 32'sd29335;
            12:      v = 32'sd14668;
            13:      v = 32'sd7334;
            14:      v = 32'sd3667;
            15:      v = 32'sd1833;
            16:      v = 32'sd917;
            17:      v = 32'sd458;
            18:      v = 32'sd229;
            19:      v = 32'sd115;
            20:      v = 32'sd57;
            21:      v = 32'sd29;
            22:      v = 32'sd14;
            23:      v = 32'sd7;
            24:      v = 32'sd4;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/vector_angle_3d.sv @@
// angle between two 3-d vectors
// throughput one vector pair per cycle while results are popped, set by the fully pipelined
// square-root, divider and cordic stages (one result bit or one rotation per stage)
// a queue between the front and back pipelines and one at the output decouple the stalls
// synchronous active-low reset empties both queues and clears all valid bits
module vector_angle_3d import vang_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [COORD_WIDTH-1:0] i_first_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_y,
    input  logic signed [COORD_WIDTH-1:0] i_first_z,
    input  logic signed [COORD_WIDTH-1:0] i_second_x,
    input  logic signed [COORD_WIDTH-1:0] i_second_y,
    input  logic signed [COORD_WIDTH-1:0] i_second_z,
    output logic                          empty,
    input  logic                          pop,
    output logic [ANG_W-1:0]              o_angle_deg,
    output logic                          o_zero_length
);

    localparam int PAIR_W = $bits(t_pair);

    logic             f_push;
    t_pair            f_pair;
    logic             mid_full, mid_empty;
    logic [PAIR_W-1:0] mid_data;
    logic             b_pop;
    logic             b_push;
    logic [ANG_W-1:0] b_angle;
    logic             b_zero;
    logic             out_full;
    logic [ANG_W:0]   out_data;

    vang_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_first_x  (i_first_x),
        .i_first_y  (i_first_y),
        .i_first_z  (i_first_z),
        .i_second_x (i_second_x),
        .i_second_y (i_second_y),
        .i_second_z (i_second_z),
        .o_push     (f_push),
        .o_pair     (f_pair),
        .i_q_full   (mid_full)
    );

    vang_fifo #(.W(PAIR_W), .DEPTH(QUEUE_DEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_pair),
        .o_full  (mid_full),
        .i_pop   (b_pop),
        .o_data  (mid_data),
        .o_empty (mid_empty)
    );

    vang_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (!mid_empty),
        .i_pair        (t_pair'(mid_data)),
        .o_pop         (b_pop),
        .i_out_full    (out_full),
        .o_push        (b_push),
        .o_angle_deg   (b_angle),
        .o_zero_length (b_zero)
    );

    vang_fifo #(.W(ANG_W + 1), .DEPTH(QUEUE_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_push),
        .i_data  ({b_zero, b_angle}),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_empty (empty)
    );

    assign o_angle_deg   = out_data[ANG_W-1:0];
    assign o_zero_length = out_data[ANG_W];

endmodule

@@ rtl/vang_fifo.sv @@
// small first-word-fall-through queue
module vang_fifo import vang_pkg::*; #(
    parameter int W     = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_slot [0:DEPTH-1];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) r_wr <= r_wr + 1'b1;
            if (rd_en) r_rd <= r_rd + 1'b1;
            if (wr_en && !rd_en)      r_cnt <= r_cnt + 1'b1;
            else if (rd_en && !wr_en) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_slot[r_wr] <= i_data;
    end

endmodule

@@ rtl/vang_front.sv @@
// front end: magnitudes, zero check and power-of-two normalisation of both vectors
module vang_front import vang_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic signed [COORD_WIDTH-1:0] i_first_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_y,
    input  logic signed [COORD_WIDTH-1:0] i_first_z,
    input  logic signed [COORD_WIDTH-1:0] i_second_x,
    input  logic signed [COORD_WIDTH-1:0] i_second_y,
    input  logic signed [COORD_WIDTH-1:0] i_second_z,
    output logic                          o_push,
    output t_pair                         o_pair,
    input  logic                          i_q_full
);

    localparam int CW = COORD_WIDTH;
    localparam int PW = ($clog2(CW) > 5) ? $clog2(CW) : 5;

    function automatic logic [PW-1:0] msb_pos(input logic [CW-1:0] v);
        logic [PW-1:0] p;
        p = '0;
        for (int i = 0; i < CW; i++) begin
            if (v[i]) p = PW'(i);
        end
        return p;
    endfunction

    function automatic logic [MAG_W-1:0] norm_mag(input logic [CW-1:0] m,
                                                  input logic [PW-1:0] p);
        logic [CW+MAG_W-1:0] w;
        w = {{MAG_W{1'b0}}, m};
        if (p > PW'(TOP_BIT)) w = w >> (p - PW'(TOP_BIT));
        else                  w = w << (PW'(TOP_BIT) - p);
        return w[MAG_W-1:0];
    endfunction

    logic          adv;
    logic [CW-1:0] in_v [0:5];
    logic [5:0]    n_f0_neg;
    logic [CW-1:0] n_f0_mag [0:5];

    logic          r_f0_vld;
    logic [5:0]    r_f0_neg;
    logic [CW-1:0] r_f0_mag [0:5];

    logic          r_f1_vld;
    logic [5:0]    r_f1_neg;
    logic [CW-1:0] r_f1_mag [0:5];
    logic [PW-1:0] r_f1_pa, r_f1_pb;
    logic          r_f1_za, r_f1_zb;
    logic [CW-1:0] or_a, or_b;

    logic          r_f2_vld;
    t_pair         r_f2_pair;
    t_pair         n_f2_pair;

    // whole front moves together; it only holds when the queue cannot take its last stage
    assign adv    = !(r_f2_vld && i_q_full);
    assign o_full = !adv;
    assign o_push = r_f2_vld && !i_q_full;
    assign o_pair = r_f2_pair;

    assign in_v[0] = i_first_x;
    assign in_v[1] = i_first_y;
    assign in_v[2] = i_first_z;
    assign in_v[3] = i_second_x;
    assign in_v[4] = i_second_y;
    assign in_v[5] = i_second_z;

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            n_f0_neg[j] = in_v[j][CW-1];
            n_f0_mag[j] = n_f0_neg[j] ? (~in_v[j] + 1'b1) : in_v[j];
        end
    end

    assign or_a = r_f0_mag[0] | r_f0_mag[1] | r_f0_mag[2];
    assign or_b = r_f0_mag[3] | r_f0_mag[4] | r_f0_mag[5];

    always_comb begin
        n_f2_pair.zero  = r_f1_za || r_f1_zb;
        n_f2_pair.a_neg = r_f1_neg[2:0];
        n_f2_pair.b_neg = r_f1_neg[5:3];
        for (int j = 0; j < 3; j++) begin
            n_f2_pair.a_mag[j] = norm_mag(r_f1_mag[j], r_f1_pa);
            n_f2_pair.b_mag[j] = norm_mag(r_f1_mag[j+3], r_f1_pb);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_vld <= 1'b0;
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
        end else if (adv) begin
            r_f0_vld <= i_push;
            r_f1_vld <= r_f0_vld;
            r_f2_vld <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f0_neg  <= n_f0_neg;
            r_f0_mag  <= n_f0_mag;
            r_f1_neg  <= r_f0_neg;
            r_f1_mag  <= r_f0_mag;
            r_f1_pa   <= msb_pos(or_a);
            r_f1_pb   <= msb_pos(or_b);
            r_f1_za   <= (or_a == '0);
            r_f1_zb   <= (or_b == '0);
            r_f2_pair <= n_f2_pair;
        end
    end

endmodule

@@ rtl/vang_sqrt.sv @@
// pipelined integer square root, one result bit per stage, with sideband
module vang_sqrt import vang_pkg::*; #(
    parameter int RW = RAD_W,
    parameter int SW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_vld,
    input  logic [RW-1:0]   i_rad,
    input  logic [SW-1:0]   i_side,
    output logic            o_vld,
    output logic [RW/2-1:0] o_root,
    output logic [SW-1:0]   o_side
);

    localparam int RT = RW / 2;

    logic          r_vld  [0:RT-1];
    logic [RW-1:0] r_rad  [0:RT-1];
    logic [RT+1:0] r_rem  [0:RT-1];
    logic [RT-1:0] r_root [0:RT-1];
    logic [SW-1:0] r_side [0:RT-1];

    for (genvar k = 0; k < RT; k++) begin : g_st
        logic          p_vld;
        logic [RW-1:0] p_rad;
        logic [RT+1:0] p_rem;
        logic [RT-1:0] p_root;
        logic [SW-1:0] p_side;
        logic [RT+3:0] rem2;
        logic [RT+1:0] trial;
        logic [RT+1:0] n_rem;
        logic [RT-1:0] n_root;

        if (k == 0) begin : g_in
            assign p_vld  = i_vld;
            assign p_rad  = i_rad;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_side = i_side;
        end else begin : g_mid
            assign p_vld  = r_vld[k-1];
            assign p_rad  = r_rad[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_side = r_side[k-1];
        end

        assign rem2  = {p_rem, p_rad[RW-1 -: 2]};
        assign trial = {p_root, 2'b01};

        always_comb begin
            if (rem2 >= (RT+4)'(trial)) begin
                n_rem  = (RT+2)'(rem2 - (RT+4)'(trial));
                n_root = {p_root[RT-2:0], 1'b1};
            end else begin
                n_rem  = (RT+2)'(rem2);
                n_root = {p_root[RT-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_adv) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rad[k]  <= p_rad << 2;
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[RT-1];
    assign o_root = r_root[RT-1];
    assign o_side = r_side[RT-1];

endmodule

@@ rtl/vang_back.sv @@
// back end: dot product, norms, cosine division, sine and arccos cordic
module vang_back import vang_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  t_pair            i_pair,
    output logic             o_pop,
    input  logic             i_out_full,
    output logic             o_push,
    output logic [ANG_W-1:0] o_angle_deg,
    output logic             o_zero_length
);

    localparam int NUM_W = RAD_W;
    localparam int DIV_W = NUM_W + 1;
    localparam int NC    = CORDIC_STEPS;

    logic adv;

    // products
    logic              r_p_vld, r_p_zero;
    logic [2:0]        r_p_neg;
    logic [PROD_W-1:0] r_p_ab [0:2];
    logic [PROD_W-1:0] r_p_aa [0:2];
    logic [PROD_W-1:0] r_p_bb [0:2];

    // sums
    logic                    r_s_vld, r_s_zero;
    logic signed [DOT_W-1:0] r_s_dot, n_s_dot;
    logic [SUM_W-1:0]        r_s_nu2, r_s_nv2;

    // norms
    logic                    a_vld;
    logic [ROOT_W-1:0]       nu, nv;
    logic [DOT_W:0]          a_side;

    // denominator product
    logic                    r_m_vld, r_m_zero;
    logic signed [DOT_W-1:0] r_m_dot;
    logic [2*ROOT_W-1:0]     r_m_prod;

    // divider set-up
    logic [DEN_W-1:0]        n_d_den;
    logic [DOT_W-2:0]        n_d_abs;
    logic                    r_d_vld, r_d_zero, r_d_neg;
    logic [DEN_W-1:0]        r_d_den;
    logic [NUM_W-1:0]        r_d_num;
    logic                    r_e_vld, r_e_zero, r_e_neg, r_e_ovf;
    logic [DEN_W-1:0]        r_e_den;
    logic [NUM_W-1:0]        r_e_num;

    // divider stages
    logic             r_v_vld  [0:Q_W-1];
    logic             r_v_zero [0:Q_W-1];
    logic             r_v_neg  [0:Q_W-1];
    logic             r_v_ovf  [0:Q_W-1];
    logic [DEN_W-1:0] r_v_den  [0:Q_W-1];
    logic [NUM_W-1:0] r_v_rem  [0:Q_W-1];
    logic [Q_W-1:0]   r_v_q    [0:Q_W-1];

    // cosine and its square
    logic                r_q_vld, r_q_zero, r_q_neg;
    logic [Q_W-1:0]      r_q_q;
    logic                r_qq_vld, r_qq_zero, r_qq_neg;
    logic [Q_W-1:0]      r_qq_q;
    logic [2*Q_W-1:0]    r_qq_sq;

    // sine
    logic                c_vld;
    logic [ROOT_W-1:0]   sn;
    logic [Q_W+1:0]      c_side;

    // cordic
    logic                    r_c_vld  [0:NC];
    logic                    r_c_zero [0:NC];
    logic signed [CX_W-1:0]  r_c_x    [0:NC];
    logic signed [CX_W-1:0]  r_c_y    [0:NC];
    logic signed [Z_W-1:0]   r_c_z    [0:NC];

    logic [Z_W-1:0]          z_rnd;
    logic [Z_W-5:0]          z_q16;

    // the whole back pipeline moves together and holds only when its last result cannot leave
    assign adv    = !(r_c_vld[NC] && i_out_full);
    assign o_pop  = adv && i_vld;
    assign o_push = r_c_vld[NC] && !i_out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld  <= 1'b0;
            r_s_vld  <= 1'b0;
            r_m_vld  <= 1'b0;
            r_d_vld  <= 1'b0;
            r_e_vld  <= 1'b0;
            r_q_vld  <= 1'b0;
            r_qq_vld <= 1'b0;
        end else if (adv) begin
            r_p_vld  <= i_vld;
            r_s_vld  <= r_p_vld;
            r_m_vld  <= a_vld;
            r_d_vld  <= r_m_vld;
            r_e_vld  <= r_d_vld;
            r_q_vld  <= r_v_vld[Q_W-1];
            r_qq_vld <= r_q_vld;
        end
    end

    always_comb begin
        n_s_dot = '0;
        for (int j = 0; j < 3; j++) begin
            if (r_p_neg[j]) n_s_dot = n_s_dot - $signed(DOT_W'(r_p_ab[j]));
            else            n_s_dot = n_s_dot + $signed(DOT_W'(r_p_ab[j]));
        end
    end

    always_comb begin
        n_d_den = r_m_prod[2*ROOT_W-1:DEN_SH];
        if (n_d_den == '0) n_d_den = DEN_W'(1);
        n_d_abs = r_m_dot[DOT_W-1] ? (DOT_W-1)'(-r_m_dot) : (DOT_W-1)'(r_m_dot);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                r_p_ab[j] <= PROD_W'(i_pair.a_mag[j]) * PROD_W'(i_pair.b_mag[j]);
                r_p_aa[j] <= PROD_W'(i_pair.a_mag[j]) * PROD_W'(i_pair.a_mag[j]);
                r_p_bb[j] <= PROD_W'(i_pair.b_mag[j]) * PROD_W'(i_pair.b_mag[j]);
            end
            r_p_neg  <= i_pair.a_neg ^ i_pair.b_neg;
            r_p_zero <= i_pair.zero;

            r_s_dot  <= n_s_dot;
            r_s_nu2  <= SUM_W'(r_p_aa[0]) + SUM_W'(r_p_aa[1]) + SUM_W'(r_p_aa[2]);
            r_s_nv2  <= SUM_W'(r_p_bb[0]) + SUM_W'(r_p_bb[1]) + SUM_W'(r_p_bb[2]);
            r_s_zero <= r_p_zero;

            r_m_prod <= (2*ROOT_W)'(nu) * (2*ROOT_W)'(nv);
            r_m_dot  <= a_side[DOT_W-1:0];
            r_m_zero <= a_side[DOT_W];

            r_d_den  <= n_d_den;
            r_d_num  <= {n_d_abs, {NORM_SH{1'b0}}};
            r_d_neg  <= r_m_dot[DOT_W-1];
            r_d_zero <= r_m_zero;

            // a quotient of 2^31 or more saturates anyway
            r_e_ovf  <= {1'b0, r_d_num} >= {r_d_den, {Q_W{1'b0}}};
            r_e_den  <= r_d_den;
            r_e_num  <= r_d_num;
            r_e_neg  <= r_d_neg;
            r_e_zero <= r_d_zero;

            r_q_q    <= (r_v_ovf[Q_W-1] || (r_v_q[Q_W-1] > ONE_Q30)) ? ONE_Q30 : r_v_q[Q_W-1];
            r_q_neg  <= r_v_neg[Q_W-1];
            r_q_zero <= r_v_zero[Q_W-1];

            r_qq_sq   <= (2*Q_W)'(r_q_q) * (2*Q_W)'(r_q_q);
            r_qq_q    <= r_q_q;
            r_qq_neg  <= r_q_neg;
            r_qq_zero <= r_q_zero;
        end
    end

    vang_sqrt #(.RW(RAD_W), .SW(DOT_W + 1)) u_norm_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_vld   (r_s_vld),
        .i_rad   ({r_s_nu2, {NORM_SH{1'b0}}}),
        .i_side  ({r_s_zero, r_s_dot}),
        .o_vld   (a_vld),
        .o_root  (nu),
        .o_side  (a_side)
    );

    vang_sqrt #(.RW(RAD_W), .SW(1)) u_norm_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_vld   (r_s_vld),
        .i_rad   ({r_s_nv2, {NORM_SH{1'b0}}}),
        .i_side  (r_s_zero),
        .o_vld   (),
        .o_root  (nv),
        .o_side  ()
    );

    // restoring division, quotient bits 30 down to 0
    for (genvar k = 0; k < Q_W; k++) begin : g_div
        localparam int B = Q_W - 1 - k;
        logic             p_vld, p_zero, p_neg, p_ovf;
        logic [DEN_W-1:0] p_den;
        logic [NUM_W-1:0] p_rem;
        logic [Q_W-1:0]   p_q;
        logic [DIV_W-1:0] dsh;
        logic             ge;

        if (k == 0) begin : g_in
            assign p_vld  = r_e_vld;
            assign p_zero = r_e_zero;
            assign p_neg  = r_e_neg;
            assign p_ovf  = r_e_ovf;
            assign p_den  = r_e_den;
            assign p_rem  = r_e_num;
            assign p_q    = '0;
        end else begin : g_mid
            assign p_vld  = r_v_vld[k-1];
            assign p_zero = r_v_zero[k-1];
            assign p_neg  = r_v_neg[k-1];
            assign p_ovf  = r_v_ovf[k-1];
            assign p_den  = r_v_den[k-1];
            assign p_rem  = r_v_rem[k-1];
            assign p_q    = r_v_q[k-1];
        end

        assign dsh = DIV_W'(p_den) << B;
        assign ge  = {1'b0, p_rem} >= dsh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v_vld[k] <= 1'b0;
            end else if (adv) begin
                r_v_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_v_zero[k] <= p_zero;
                r_v_neg[k]  <= p_neg;
                r_v_ovf[k]  <= p_ovf;
                r_v_den[k]  <= p_den;
                r_v_rem[k]  <= ge ? (p_rem - dsh[NUM_W-1:0]) : p_rem;
                r_v_q[k]    <= p_q | (ge ? (Q_W'(1) << B) : '0);
            end
        end
    end

    vang_sqrt #(.RW(RAD_W), .SW(Q_W + 2)) u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_vld   (r_qq_vld),
        .i_rad   (ONE_Q60 - r_qq_sq),
        .i_side  ({r_qq_zero, r_qq_neg, r_qq_q}),
        .o_vld   (c_vld),
        .o_root  (sn),
        .o_side  (c_side)
    );

    // starting vector; negative cosines get a quarter-turn pre-rotation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld[0] <= 1'b0;
        end else if (adv) begin
            r_c_vld[0] <= c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_zero[0] <= c_side[Q_W+1];
            // a cosine that rounds to zero counts as non-negative
            if (c_side[Q_W] && c_side[Q_W-1:0] != '0) begin
                r_c_x[0] <= $signed(CX_W'(sn));
                r_c_y[0] <= $signed(CX_W'(c_side[Q_W-1:0]));
                r_c_z[0] <= Z_PREROT;
            end else begin
                r_c_x[0] <= $signed(CX_W'(c_side[Q_W-1:0]));
                r_c_y[0] <= $signed(CX_W'(sn));
                r_c_z[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < NC; k++) begin : g_cordic
        logic signed [CX_W-1:0] xs, ys;

        assign xs = r_c_x[k] >>> k;
        assign ys = r_c_y[k] >>> k;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_vld[k+1] <= 1'b0;
            end else if (adv) begin
                r_c_vld[k+1] <= r_c_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_c_zero[k+1] <= r_c_zero[k];
                if (r_c_y[k] > 0) begin
                    r_c_x[k+1] <= r_c_x[k] + ys;
                    r_c_y[k+1] <= r_c_y[k] - xs;
                    r_c_z[k+1] <= r_c_z[k] + atan_q20(k);
                end else begin
                    r_c_x[k+1] <= r_c_x[k] - ys;
                    r_c_y[k+1] <= r_c_y[k] + xs;
                    r_c_z[k+1] <= r_c_z[k] - atan_q20(k);
                end
            end
        end
    end

    // round half up from q.20 to q.16, clamp to 0 to 180 degrees, and give 0 for a zero-length pair
    assign z_rnd = Z_W'(r_c_z[NC]) + Z_W'(8);
    assign z_q16 = z_rnd[Z_W-1:4];

    always_comb begin
        o_zero_length = r_c_zero[NC];
        if (r_c_zero[NC] || r_c_z[NC] <= 0) begin
            o_angle_deg = '0;
        end else if (z_q16 > (Z_W-4)'(ANGLE_MAX)) begin
            o_angle_deg = ANGLE_MAX;
        end else begin
            o_angle_deg = z_q16[ANG_W-1:0];
        end
    end

endmodule
